/* rtl/rfcf_pkg.sv */
// rfcf_pkg: shared types, constants and frame builder for the command framer
// depends on nothing; imported by rfcf_bit_shifter and rfid_reader_command_framer_unit
package rfcf_pkg;

   // command bits, sent msb first
   localparam logic [3:0] CMD_READ  = 4'h9;
   localparam logic [3:0] CMD_WRITE = 4'h5;

   // request kinds
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // frame lengths in bits, not counting the first stop
   localparam int FRAME_BITS = 56;
   localparam int READ_BITS  = 11;
   localparam int CNT_W      = $clog2(FRAME_BITS + 1);

   // configuration register indexes
   localparam logic [1:0] REG_STOP_OFF = 2'd0;
   localparam logic [1:0] REG_ONE_ON   = 2'd1;
   localparam logic [1:0] REG_ZERO_ON  = 2'd2;
   localparam logic [1:0] REG_ZERO_OFF = 2'd3;

   // register reset values
   localparam logic [7:0] RST_STOP_OFF = 8'd55;
   localparam logic [7:0] RST_ONE_ON   = 8'd32;
   localparam logic [7:0] RST_ZERO_ON  = 8'd18;
   localparam logic [7:0] RST_ZERO_OFF = 8'd14;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STOP,
      ST_BITS
   } state_type;

   // sequencer to shifter
   typedef struct packed {
      logic load;
      logic shift;
      logic is_write;
   } shf_ctrl_type;

   // shifter to sequencer
   typedef struct packed {
      logic bit_value;
      logic last;
   } shf_stat_type;

   // whole frame msb first; a read uses only the top READ_BITS bits
   function automatic logic [FRAME_BITS-1:0] build_frame(
      input logic        is_write,
      input logic [3:0]  addr,
      input logic [31:0] word
   );
      logic [3:0] cmd;
      logic [7:0] col;
      cmd = is_write ? CMD_WRITE : CMD_READ;
      col = word[31:24] ^ word[23:16] ^ word[15:8] ^ word[7:0];
      return {cmd, addr, 2'b00, ^addr,
              word[31:24], ^word[31:24],
              word[23:16], ^word[23:16],
              word[15:8],  ^word[15:8],
              word[7:0],   ^word[7:0],
              col, 1'b0};
   endfunction

endpackage

/* rtl/rfid_reader_command_framer_unit.sv */
// A taken request enters the first stop state, then its segment is registered.
// Throughput: one segment per cycle while rsp_stall is low; a read frame is
// 12 segments, a write frame 57, set by the frame shift register.
// A new request is taken the cycle after the last segment is registered.
// Reset is synchronous: sequencer idle, output empty, tick registers at defaults.
module rfid_reader_command_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [3:0]  req_word_address,
   input  logic [31:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_on_ticks,
   output logic [7:0]  rsp_off_ticks,
   output logic        rsp_bit_value,
   output logic        rsp_last_segment,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   import rfcf_pkg::*;

   state_type    state_ff, state_in;
   shf_ctrl_type shf_ctrl;
   shf_stat_type shf_stat;

   logic [7:0] stop_off_ff, one_on_ff, zero_on_ff, zero_off_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] on_ticks_ff, off_ticks_ff;
   logic       bit_value_ff, last_ff;

   logic accept;
   logic out_free;
   logic emit;
   logic emit_stop;

   // tick registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_off_ff <= RST_STOP_OFF;
         one_on_ff   <= RST_ONE_ON;
         zero_on_ff  <= RST_ZERO_ON;
         zero_off_ff <= RST_ZERO_OFF;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_STOP_OFF: stop_off_ff <= csr_write_data;
            REG_ONE_ON:   one_on_ff   <= csr_write_data;
            REG_ZERO_ON:  zero_on_ff  <= csr_write_data;
            REG_ZERO_OFF: zero_off_ff <= csr_write_data;
            default:      ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept)   state_in = ST_STOP;
         ST_STOP: if (out_free) state_in = ST_BITS;
         ST_BITS: if (out_free && shf_stat.last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      emit              = 1'b0;
      emit_stop         = 1'b0;
      shf_ctrl.load     = 1'b0;
      shf_ctrl.shift    = 1'b0;
      shf_ctrl.is_write = (req_func == FUNC_WRITE);
      unique case (state_ff)
         ST_IDLE: shf_ctrl.load = accept;
         ST_STOP: begin
            emit      = out_free;
            emit_stop = out_free;
         end
         ST_BITS: begin
            emit           = out_free;
            shf_ctrl.shift = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   rfcf_bit_shifter u_shifter (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (shf_ctrl),
      .word_address (req_word_address),
      .write_value  (req_write_value),
      .stat         (shf_stat)
   );

   // output register: valid holds while stalled
   assign rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // segment payload
   always_ff @(posedge clock) begin
      if (emit) begin
         if (emit_stop) begin
            on_ticks_ff  <= 8'd0;
            off_ticks_ff <= stop_off_ff;
            bit_value_ff <= 1'b0;
            last_ff      <= 1'b0;
         end else begin
            on_ticks_ff  <= shf_stat.bit_value ? one_on_ff : zero_on_ff;
            off_ticks_ff <= shf_stat.bit_value ? 8'd0 : zero_off_ff;
            bit_value_ff <= shf_stat.bit_value;
            last_ff      <= shf_stat.last;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_on_ticks     = on_ticks_ff;
   assign rsp_off_ticks    = off_ticks_ff;
   assign rsp_bit_value    = bit_value_ff;
   assign rsp_last_segment = last_ff;

   // a taken request always opens with the first stop
   a_accept_to_stop: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_STOP))
      else $error("request accepted without entering first stop");

   // the first stop segment never closes a frame
   a_stop_not_last: assert property (@(posedge clock) disable iff (reset)
      emit_stop |=> (rsp_valid && !rsp_last_segment && rsp_on_ticks == 8'd0))
      else $error("first stop segment malformed");

   // emitting the final bit returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BITS && emit && shf_stat.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not go idle after final segment");

   // no segment is pushed while idle
   a_idle_no_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !emit)
      else $error("segment emitted while idle");

endmodule

/* rtl/rfcf_bit_shifter.sv */
// rfcf_bit_shifter: frame shift register and bit counter, one bit per shift
// depends on rfcf_pkg
module rfcf_bit_shifter (
   input  logic                 clock,
   input  logic                 reset,
   input  rfcf_pkg::shf_ctrl_type ctrl,
   input  logic [3:0]           word_address,
   input  logic [31:0]          write_value,
   output rfcf_pkg::shf_stat_type stat
);
   import rfcf_pkg::*;

   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   // load a fresh frame or shift out the msb
   always_comb begin
      frame_in = frame_ff;
      count_in = count_ff;
      if (ctrl.load) begin
         frame_in = build_frame(ctrl.is_write, word_address, write_value);
         count_in = ctrl.is_write ? CNT_W'(FRAME_BITS) : CNT_W'(READ_BITS);
      end else if (ctrl.shift) begin
         frame_in = {frame_ff[FRAME_BITS-2:0], 1'b0};
         count_in = count_ff - CNT_W'(1);
      end
   end

   // frame bits carry no reset
   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.bit_value = frame_ff[FRAME_BITS-1];
   assign stat.last      = (count_ff == CNT_W'(1));

endmodule
